>>> src/acdc_pkg.sv
`default_nettype none
package acdc_pkg;

  localparam int VALUES_PER_BLOCK = 15;
  localparam int BLOCKS_PER_MB    = 6;
  localparam int MB_STRIDE        = VALUES_PER_BLOCK * BLOCKS_PER_MB;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PREDICT = 2'd1;
  localparam logic [1:0] KIND_ADD     = 2'd2;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_VERT  = 2'd1;
  localparam logic [1:0] DIR_HORIZ = 2'd2;

  localparam logic signed [16:0] DC_MISSING = 17'sd1024;
  localparam logic [2:0]         LAST_BLOCK = 3'd5;
  localparam logic [3:0]         LAST_POS   = 4'd14;
  localparam logic [3:0]         ROW_LAST   = 4'd7;

  localparam int NUM_W = 22;
  localparam int DEN_W = 6;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

endpackage
`default_nettype wire

>>> src/mpeg4_acdc_intra_prediction_core.sv
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser kind, tdata item fields
// m_*       out  m_tvalid/m_tready  tuser slot, tdata value/direction, tlast
// cfg_*     in   cfg_valid/cfg_ready cfg_data = mb_width
//
// After reset the macroblock table is cleared, all 2*MAX_MB_COLS entries, no requests taken.
// Header: table entry written on acceptance. Add: store write and result, held by output stall.
// Predict: table/store reads, then 8 results, each one pass
// through the shared 22-step divider (1 bit per cycle).
// Output register stall holds the sequencer; input not ready until item done.
module mpeg4_acdc_intra_prediction_core #(
  parameter int MAX_MB_COLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // mb_x, mb_y, is_intra, quant, block_index,
                                     // dc_scaler, ac_pred_enable, position, residual
  input  wire logic [1:0]  s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // value, direction
  output logic [3:0]       m_tuser,  // slot
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int IDEPTH = 2 * MAX_MB_COLS;
  localparam int IAW    = $clog2(IDEPTH);
  localparam int SDEPTH = IDEPTH * acdc_pkg::MB_STRIDE;
  localparam int SAW    = $clog2(SDEPTH);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_INFO  = 4'd2;
  localparam logic [3:0] ST_SEL   = 4'd3;
  localparam logic [3:0] ST_DC    = 4'd4;
  localparam logic [3:0] ST_DIR   = 4'd5;
  localparam logic [3:0] ST_DIVS  = 4'd6;
  localparam logic [3:0] ST_DIVW  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;
  localparam logic [3:0] ST_RD    = 4'd9;
  localparam logic [3:0] ST_RDW   = 4'd10;
  localparam logic [3:0] ST_ADD   = 4'd11;

  logic [3:0] state;
  logic [1:0] cnt;
  logic [2:0] idx;
  logic [IAW-1:0] clr_cnt;
  logic [7:0] mb_width;

  // input fields
  logic [6:0]  in_x;
  logic [7:0]  in_y;
  logic        in_intra;
  logic [4:0]  in_quant;
  logic [2:0]  in_blk;
  logic [5:0]  in_scl;
  logic        in_acp;
  logic [3:0]  in_pos;
  logic [15:0] in_res;
  logic [4:0]  in_cq;
  logic        accept;
  logic        col_ok;
  logic [IAW-1:0] in_cur;

  assign in_x     = s_tdata[6:0];
  assign in_y     = s_tdata[14:7];
  assign in_intra = s_tdata[15];
  assign in_quant = s_tdata[20:16];
  assign in_blk   = s_tdata[23:21];
  assign in_scl   = s_tdata[29:24];
  assign in_acp   = s_tdata[30];
  assign in_pos   = s_tdata[34:31];
  assign in_res   = s_tdata[50:35];
  assign in_cq    = (in_quant == '0) ? 5'd1 : in_quant;
  assign accept   = s_tvalid && s_tready;
  assign col_ok   = ({1'b0, in_x} < mb_width) && (32'(in_x) < MAX_MB_COLS);
  assign in_cur   = IAW'(32'(in_y[0]) * MAX_MB_COLS + 32'(in_x));

  // latched item
  logic        row_r;
  logic        ynz_r;
  logic [6:0]  x_r;
  logic [4:0]  cq_r;
  logic [2:0]  blk_r;
  logic        acp_r;
  logic [3:0]  pos_r;
  logic [15:0] res_r;
  logic [IAW-1:0] cur_r;

  // block state
  logic [1:0]  block_dir;
  logic [5:0]  scaler;
  logic [15:0] lp [8];

  // neighbour info
  logic [5:0] linfo, tinfo, dinfo;
  logic       lv, tv, dv;
  logic [SAW-1:0] lbase, tbase, dbase;
  logic [4:0] lq, tq;
  logic signed [16:0] dc_l, dc_t, dc_d;
  logic [IAW-1:0] lidx, tidx, didx;

  assign lidx = IAW'(32'(row_r) * MAX_MB_COLS + 32'(x_r) - 32'd1);
  assign tidx = IAW'(32'(~row_r) * MAX_MB_COLS + 32'(x_r));
  assign didx = IAW'(32'(~row_r) * MAX_MB_COLS + 32'(x_r) - 32'd1);

  function automatic logic [SAW-1:0] blk_base(input logic [IAW-1:0] mb, input logic [2:0] b);
    blk_base = SAW'(32'(mb) * acdc_pkg::MB_STRIDE + 32'(b) * acdc_pkg::VALUES_PER_BLOCK);
  endfunction

  // neighbour selection
  logic       lok, tok, dok;
  logic       sel_lv, sel_tv, sel_dv;
  logic [IAW-1:0] sel_lm, sel_tm, sel_dm;
  logic [2:0] sel_lb, sel_tb, sel_db;
  logic [4:0] sel_lq, sel_tq;

  assign lok = (x_r != '0) && linfo[5];
  assign tok = ynz_r && tinfo[5];
  assign dok = (x_r != '0) && ynz_r && dinfo[5];

  always_comb begin
    sel_lq = lok ? linfo[4:0] : cq_r;
    sel_tq = tok ? tinfo[4:0] : cq_r;
    sel_lv = lok; sel_lm = lidx; sel_lb = in_blk_dummy(blk_r);
    sel_tv = tok; sel_tm = tidx; sel_tb = blk_r;
    sel_dv = dok; sel_dm = didx; sel_db = blk_r;
    case (blk_r)
      3'd0: begin
        sel_lb = 3'd1; sel_tb = 3'd2; sel_db = 3'd3;
      end
      3'd1: begin
        sel_lv = 1'b1; sel_lm = cur_r; sel_lb = 3'd0; sel_lq = cq_r;
        sel_tb = 3'd3;
        sel_dv = tok; sel_dm = tidx; sel_db = 3'd2;
      end
      3'd2: begin
        sel_lb = 3'd3;
        sel_dv = lok; sel_dm = lidx; sel_db = 3'd1;
        sel_tv = 1'b1; sel_tm = cur_r; sel_tb = 3'd0; sel_tq = cq_r;
      end
      3'd3: begin
        sel_lv = 1'b1; sel_lm = cur_r; sel_lb = 3'd2; sel_lq = cq_r;
        sel_tv = 1'b1; sel_tm = cur_r; sel_tb = 3'd1; sel_tq = cq_r;
        sel_dv = 1'b1; sel_dm = cur_r; sel_db = 3'd0;
      end
      default: begin
      end
    endcase
  end

  function automatic logic [2:0] in_blk_dummy(input logic [2:0] b);
    in_blk_dummy = b;
  endfunction

  // direction
  logic signed [17:0] dl, dt;
  logic [17:0] adl, adt;
  logic        vert;

  assign dl   = 18'(dc_l) - 18'(dc_d);
  assign dt   = 18'(dc_d) - 18'(dc_t);
  assign adl  = dl[17] ? 18'(-dl) : 18'(dl);
  assign adt  = dt[17] ? 18'(-dt) : 18'(dt);
  assign vert = adl < adt;

  // memories
  logic           info_we;
  logic [IAW-1:0] info_waddr, info_raddr;
  logic [5:0]     info_wdata, info_rdata;
  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [15:0]    st_wdata, st_rdata;

  assign info_we    = (state == ST_CLEAR) ||
                      (accept && col_ok && s_tuser == acdc_pkg::KIND_HEADER);
  assign info_waddr = (state == ST_CLEAR) ? clr_cnt : in_cur;
  assign info_wdata = (state == ST_CLEAR) ? 6'd0 : {in_intra, in_cq};

  always_comb begin
    case (cnt)
      2'd0:    info_raddr = lidx;
      2'd1:    info_raddr = tidx;
      default: info_raddr = didx;
    endcase
  end

  acdc_ram #(.WIDTH(6), .DEPTH(IDEPTH)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );

  logic           src_v;
  logic [SAW-1:0] src_base;
  logic [4:0]     src_q;

  assign src_v    = (block_dir == acdc_pkg::DIR_VERT) ? tv : lv;
  assign src_base = (block_dir == acdc_pkg::DIR_VERT) ? tbase : lbase;
  assign src_q    = (block_dir == acdc_pkg::DIR_VERT) ? tq : lq;

  always_comb begin
    if (state == ST_DC) begin
      case (cnt)
        2'd0:    st_raddr = lbase;
        2'd1:    st_raddr = tbase;
        default: st_raddr = dbase;
      endcase
    end else begin
      st_raddr = src_base + SAW'(idx) +
                 ((block_dir == acdc_pkg::DIR_HORIZ) ? SAW'(7) : SAW'(0));
    end
  end

  // add path
  logic        out_free;
  logic [2:0]  lp_sel;
  logic [15:0] add_v;
  logic        use_pred;

  assign out_free = !m_tvalid || m_tready;
  assign lp_sel   = (pos_r <= acdc_pkg::ROW_LAST) ? pos_r[2:0] : 3'(pos_r - 4'd7);
  always_comb begin
    if (pos_r == '0) begin
      use_pred = 1'b1;
    end else if (pos_r <= acdc_pkg::ROW_LAST) begin
      use_pred = acp_r && block_dir == acdc_pkg::DIR_VERT;
    end else begin
      use_pred = acp_r && block_dir == acdc_pkg::DIR_HORIZ;
    end
  end
  assign add_v    = use_pred ? res_r + lp[lp_sel] : res_r;

  assign st_we    = (state == ST_ADD) && out_free;
  assign st_waddr = blk_base(cur_r, blk_r) + SAW'(pos_r);
  assign st_wdata = (pos_r == '0) ? 16'(add_v * {10'd0, scaler}) : add_v;

  acdc_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // divider
  acdc_pkg::div_req_t div_req;
  logic               div_done;
  logic signed [15:0] div_q;
  logic [15:0]        coeff;

  assign coeff = src_v ? st_rdata : 16'd0;

  acdc_div u_div (
    .clk(clk), .rst(rst), .start(state == ST_DIVS), .req(div_req),
    .done(div_done), .quot(div_q)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cnt       <= '0;
      idx       <= '0;
      mb_width  <= 8'd1;
      block_dir <= acdc_pkg::DIR_NONE;
      scaler    <= 6'd1;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        lp[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        mb_width <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IAW'(IDEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          cnt <= '0;
          if (accept && col_ok && in_blk <= acdc_pkg::LAST_BLOCK) begin
            if (s_tuser == acdc_pkg::KIND_PREDICT) begin
              scaler <= (in_scl == '0) ? 6'd1 : in_scl;
              state  <= ST_INFO;
            end else if (s_tuser == acdc_pkg::KIND_ADD && in_pos <= acdc_pkg::LAST_POS) begin
              state <= ST_ADD;
            end
          end
        end
        ST_INFO: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= ST_SEL;
          end
        end
        ST_SEL: begin
          cnt   <= '0;
          state <= ST_DC;
        end
        ST_DC: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= ST_DIR;
          end
        end
        ST_DIR: begin
          idx       <= '0;
          block_dir <= vert ? acdc_pkg::DIR_VERT : acdc_pkg::DIR_HORIZ;
          state     <= ST_DIVS;
        end
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            lp[idx] <= div_q;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (idx == 3'd7) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 3'd1;
              state <= ST_RD;
            end
          end
        end
        ST_RD:  state <= ST_RDW;
        ST_RDW: state <= ST_DIVS;
        ST_ADD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= in_y[0];
      ynz_r <= in_y != '0;
      x_r   <= in_x;
      cq_r  <= in_cq;
      blk_r <= in_blk;
      acp_r <= in_acp;
      pos_r <= in_pos;
      res_r <= in_res;
      cur_r <= in_cur;
    end
    if (state == ST_INFO) begin
      case (cnt)
        2'd1:    linfo <= info_rdata;
        2'd2:    tinfo <= info_rdata;
        2'd3:    dinfo <= info_rdata;
        default: linfo <= linfo;
      endcase
    end
    if (state == ST_SEL) begin
      lv    <= sel_lv;
      tv    <= sel_tv;
      dv    <= sel_dv;
      lbase <= blk_base(sel_lm, sel_lb);
      tbase <= blk_base(sel_tm, sel_tb);
      dbase <= blk_base(sel_dm, sel_db);
      lq    <= sel_lq;
      tq    <= sel_tq;
    end
    if (state == ST_DC) begin
      case (cnt)
        2'd1:    dc_l <= lv ? 17'($signed(st_rdata)) : acdc_pkg::DC_MISSING;
        2'd2:    dc_t <= tv ? 17'($signed(st_rdata)) : acdc_pkg::DC_MISSING;
        2'd3:    dc_d <= dv ? 17'($signed(st_rdata)) : acdc_pkg::DC_MISSING;
        default: dc_l <= dc_l;
      endcase
    end
    if (state == ST_DIR) begin
      div_req.num <= vert ? 22'(dc_t) : 22'(dc_l);
      div_req.den <= scaler;
    end
    if (state == ST_RDW) begin
      div_req.num <= $signed({{6{coeff[15]}}, coeff}) * $signed({17'd0, src_q});
      div_req.den <= {1'b0, cq_r};
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {6'd0, block_dir, div_q};
      m_tuser <= {1'b0, idx};
      m_tlast <= idx == 3'd7;
    end
    if (state == ST_ADD && out_free) begin
      m_tdata <= {6'd0, block_dir, add_v};
      m_tuser <= pos_r;
      m_tlast <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIVW)
    else $error("divider result outside wait state");
  assert property (@(posedge clk) disable iff (rst) st_we |-> state == ST_ADD)
    else $error("store written outside add");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> m_tvalid)
    else $error("prediction result lost");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && idx == 3'd7) |=> (m_tlast && state == ST_IDLE))
    else $error("predict did not end on slot seven");

endmodule
`default_nettype wire

>>> src/acdc_ram.sv
`default_nettype none
module acdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/acdc_div.sv
`default_nettype none
module acdc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire acdc_pkg::div_req_t req,
  output logic                   done,
  output logic signed [15:0]     quot
);

  localparam int NW = acdc_pkg::NUM_W;
  localparam int DW = acdc_pkg::DEN_W;

  logic          busy;
  logic [4:0]    cnt;
  logic          neg;
  logic [NW-1:0] num;
  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;

  logic [NW-1:0] mag;
  logic [DW:0]   r2;
  logic          qbit;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] q_next;

  // magnitude plus half the divisor, so truncation rounds half away from zero
  assign mag      = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
  assign r2       = {rem, num[NW-1]};
  assign qbit     = r2 >= {1'b0, den};
  assign rem_next = qbit ? DW'(r2 - {1'b0, den}) : r2[DW-1:0];
  assign q_next   = {q[NW-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(NW - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= req.num[NW-1];
      num <= mag + NW'(req.den >> 1);
      den <= req.den;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      rem <= rem_next;
      q   <= q_next;
      if (cnt == '0) begin
        quot <= neg ? -$signed(q_next[15:0]) : $signed(q_next[15:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(start && busy)) else $error("divider restarted while busy");
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_mpeg4_acdc_intra_prediction_core.sv
`default_nettype none
module tb_mpeg4_acdc_intra_prediction_core;
  import acdc_pkg::*;

  localparam int COLS = 128;
  localparam int STORE_N = 2 * COLS * MB_STRIDE;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [6:0]         x;
    logic [7:0]         y;
    logic               intra;
    logic [4:0]         quant;
    logic [2:0]         blk;
    logic [5:0]         scaler;
    logic               acp;
    logic [3:0]         pos;
    logic signed [15:0] res;
  } req_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         slot;
    logic [1:0]         dir;
    logic               last;
  } coeff_t;

  typedef struct {
    req_t               rq;
    bit                 chk;
    logic signed [15:0] ev;
    logic [1:0]         ed;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  mpeg4_acdc_intra_prediction_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // reference state
  logic [15:0] coef_store [STORE_N];
  bit          coef_written [STORE_N];
  logic [5:0]  mb_info [2*COLS];
  logic [15:0] pred_latch [8];
  logic [1:0]  dir_latch;
  int          scaler_latch;
  int          width_reg;

  coeff_t pending_coeffs [$];
  int     errors = 0;
  int     sent = 0;
  int     received = 0;
  int     gap_next = 0;
  bit     calm = 0;

  function automatic int sx16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return t;
  endfunction

  function automatic int div_round(int a, int b);
    int m;
    int q;
    m = (a < 0) ? -a : a;
    q = (m + (b >> 1)) / b;
    return (a < 0) ? -q : q;
  endfunction

  function automatic int rescale(int pq, int cq, int c);
    if (c == 0) return 0;
    return sx16(div_round(c * pq, cq));
  endfunction

  function automatic int blk_base(int mb, int b);
    return (mb * BLOCKS_PER_MB + b) * VALUES_PER_BLOCK;
  endfunction

  function automatic int fetch(bit ok, int base, int k);
    if (!ok) return (k == 0) ? 1024 : 0;
    return sx16(coef_store[base + k]);
  endfunction

  function automatic bool_ok(bit ok, int base);
    if (!ok) return 1;
    for (int k = 0; k < VALUES_PER_BLOCK; k++)
      if (!coef_written[base + k]) return 0;
    return 1;
  endfunction

  // -1: request would read unwritten coefficients; else number of results queued
  function automatic int acdc_step(req_t r);
    int x, row, prow, cur, q, lidx, tidx, didx, lq, tq, lb, tb, db, base, v, L, T, D, dl, dt;
    bit lok, tok, dok, lv, tv, dv;
    logic [1:0] d;
    x = r.x;
    if (x >= width_reg || x >= COLS) return 0;
    q = (r.quant == 0) ? 1 : r.quant;
    row = r.y[0];
    prow = row ^ 1;
    cur = row * COLS + x;
    if (r.kind == KIND_HEADER) begin
      mb_info[cur] = {r.intra, q[4:0]};
      return 0;
    end
    if (r.blk > LAST_BLOCK || r.kind == KIND_BAD) return 0;
    if (r.kind == KIND_PREDICT) begin
      lidx = cur - 1;
      tidx = prow * COLS + x;
      didx = tidx - 1;
      lok = (x > 0) ? mb_info[lidx][5] : 0;
      tok = (r.y > 0) ? mb_info[tidx][5] : 0;
      dok = (x > 0 && r.y > 0) ? mb_info[didx][5] : 0;
      lq = lok ? mb_info[lidx][4:0] : q;
      tq = tok ? mb_info[tidx][4:0] : q;
      lb = 0; tb = 0; db = 0;
      case (r.blk)
        3'd0: begin
          lv = lok; tv = tok; dv = dok;
          if (lok) lb = blk_base(lidx, 1);
          if (tok) tb = blk_base(tidx, 2);
          if (dok) db = blk_base(didx, 3);
        end
        3'd1: begin
          lv = 1; lb = blk_base(cur, 0); lq = q;
          tv = tok; dv = tok;
          if (tok) begin
            tb = blk_base(tidx, 3);
            db = blk_base(tidx, 2);
          end
        end
        3'd2: begin
          lv = lok; dv = lok;
          if (lok) begin
            lb = blk_base(lidx, 3);
            db = blk_base(lidx, 1);
          end
          tv = 1; tb = blk_base(cur, 0); tq = q;
        end
        3'd3: begin
          lv = 1; lb = blk_base(cur, 2); lq = q;
          tv = 1; tb = blk_base(cur, 1); tq = q;
          dv = 1; db = blk_base(cur, 0);
        end
        default: begin
          lv = lok; tv = tok; dv = dok;
          if (lok) lb = blk_base(lidx, r.blk);
          if (tok) tb = blk_base(tidx, r.blk);
          if (dok) db = blk_base(didx, r.blk);
        end
      endcase
      if (!(bool_ok(lv, lb) && bool_ok(tv, tb) && bool_ok(dv, db))) return -1;
      scaler_latch = (r.scaler == 0) ? 1 : r.scaler;
      L = fetch(lv, lb, 0);
      T = fetch(tv, tb, 0);
      D = fetch(dv, db, 0);
      dl = (L > D) ? L - D : D - L;
      dt = (D > T) ? D - T : T - D;
      if (dl < dt) begin
        d = DIR_VERT;
        pred_latch[0] = div_round(T, scaler_latch);
        for (int i = 1; i < 8; i++) pred_latch[i] = rescale(tq, q, fetch(tv, tb, i));
      end else begin
        d = DIR_HORIZ;
        pred_latch[0] = div_round(L, scaler_latch);
        for (int i = 1; i < 8; i++) pred_latch[i] = rescale(lq, q, fetch(lv, lb, i + 7));
      end
      dir_latch = d;
      for (int i = 0; i < 8; i++)
        pending_coeffs.push_back('{pred_latch[i], 4'(i), d, i == 7});
      return 8;
    end
    if (r.pos > LAST_POS) return 0;
    base = blk_base(cur, r.blk);
    if (r.pos == 0) begin
      v = sx16(r.res + sx16(pred_latch[0]));
      coef_store[base] = v * scaler_latch;
    end else begin
      v = r.res;
      if (r.pos <= ROW_LAST && r.acp && dir_latch == DIR_VERT)
        v = sx16(r.res + sx16(pred_latch[r.pos]));
      if (r.pos > ROW_LAST && r.acp && dir_latch == DIR_HORIZ)
        v = sx16(r.res + sx16(pred_latch[r.pos - 7]));
      coef_store[base + r.pos] = v;
    end
    coef_written[base + r.pos] = 1;
    pending_coeffs.push_back('{v[15:0], r.pos, dir_latch, 1'b1});
    return 1;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, received);
  endtask

  // returns at the accepting edge with s_tvalid possibly still high
  task automatic send(req_t r, bit chk = 0, int ev = 0, logic [1:0] ed = DIR_NONE);
    int n;
    coeff_t first;
    n = acdc_step(r);
    if (n < 0) return;
    if (chk && n > 0) begin
      first = pending_coeffs[pending_coeffs.size() - n];
      if (first.value !== ev[15:0]) report("table value", first.value, ev);
      if (first.dir !== ed) report("table direction", first.dir, ed);
    end
    repeat (gap_next) @(posedge clk);
    s_tdata <= {5'd0, r.res, r.pos, r.acp, r.scaler, r.blk, r.quant, r.intra, r.y, r.x};
    s_tuser <= r.kind;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sent++;
    gap_next = calm ? 0 : $urandom_range(0, 16);
    if (gap_next > 0) s_tvalid <= 0;
  endtask

  task automatic drain;
    if (gap_next == 0) s_tvalid <= 0;
    gap_next = 0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_width(int w);
    drain();
    cfg_data <= w[7:0];
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    width_reg = w;
  endtask

  function automatic req_t noise_req();
    req_t r;
    r.kind = $urandom_range(0, 3);
    r.x = (width_reg > 1 && $urandom_range(0, 3) != 0) ? $urandom_range(0, width_reg - 1)
                                                        : $urandom_range(0, 127);
    r.y = $urandom_range(0, 255);
    r.intra = $urandom_range(0, 1);
    r.quant = $urandom_range(0, 31);
    r.blk = $urandom_range(0, 7);
    r.scaler = $urandom_range(0, 63);
    r.acp = $urandom_range(0, 1);
    r.pos = $urandom_range(0, 15);
    r.res = $urandom;
    return r;
  endfunction

  task automatic macroblock(int x, int y);
    req_t r;
    int order [15];
    int j, t;
    r = '0;
    r.x = x;
    r.y = y;
    r.kind = KIND_HEADER;
    r.intra = ($urandom_range(0, 4) != 0);
    r.quant = $urandom_range(0, 31);
    send(r);
    for (int b = 0; b <= LAST_BLOCK; b++) begin
      r.kind = KIND_PREDICT;
      r.blk = b;
      r.scaler = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 63);
      r.acp = $urandom_range(0, 1);
      r.intra = $urandom_range(0, 1);
      r.pos = $urandom_range(0, 15);
      r.res = $urandom;
      send(r);
      for (int i = 0; i < 15; i++) order[i] = i;
      for (int i = 14; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      r.kind = KIND_ADD;
      for (int i = 0; i < 15; i++) begin
        r.pos = order[i];
        r.res = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(0, 600)) - 300);
        if ($urandom_range(0, 5) == 0) r.acp = ~r.acp;
        send(r);
      end
      if ($urandom_range(0, 2) == 0) send(noise_req());
    end
  endtask

  task automatic random_phase(int w, int n);
    int start;
    set_width(w);
    start = sent;
    while (sent - start < n) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) send(noise_req());
      else macroblock($urandom_range(0, w - 1), $urandom_range(0, 255));
    end
    calm = 0;
  endtask

  always @(posedge clk) begin
    int n;
    coeff_t e;
    if (rst) begin
      m_tready <= 0;
      n = 0;
    end else if (m_tvalid && m_tready) begin
      received++;
      if (pending_coeffs.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result slot %0d", m_tuser);
      end else begin
        e = pending_coeffs.pop_front();
        if (m_tdata[15:0] !== e.value) report("value", $signed(m_tdata[15:0]), e.value);
        if (m_tuser !== e.slot) report("slot", m_tuser, e.slot);
        if (m_tdata[17:16] !== e.dir) report("direction", m_tdata[17:16], e.dir);
        if (m_tlast !== e.last) report("last", m_tlast, e.last);
      end
      n = calm ? 0 : $urandom_range(0, 16);
      m_tready <= (n == 0);
    end else if (n > 0) begin
      n--;
      m_tready <= (n == 0);
    end else begin
      m_tready <= 1;
    end
  end

  row_t table_rows [13] = '{
    '{'{KIND_HEADER,  7'd0, 8'd0, 1'b1, 5'd0,  3'd0, 6'd0,  1'b0, 4'd0,  16'sd0},
      0, 0, DIR_NONE},
    '{'{KIND_PREDICT, 7'd0, 8'd0, 1'b0, 5'd0,  3'd0, 6'd0,  1'b0, 4'd0,  16'sd0},
      1, 1024, DIR_HORIZ},
    '{'{KIND_PREDICT, 7'd0, 8'd0, 1'b0, 5'd0,  3'd0, 6'd8,  1'b0, 4'd0,  16'sd0},
      1, 128, DIR_HORIZ},
    '{'{KIND_ADD,     7'd0, 8'd0, 1'b0, 5'd0,  3'd0, 6'd8,  1'b1, 4'd0,  16'sd32767},
      1, -32641, DIR_HORIZ},
    '{'{KIND_ADD,     7'd0, 8'd0, 1'b0, 5'd0,  3'd0, 6'd8,  1'b1, 4'd7,  -16'sd32768},
      1, -32768, DIR_HORIZ},
    '{'{KIND_ADD,     7'd0, 8'd0, 1'b0, 5'd0,  3'd0, 6'd8,  1'b1, 4'd14, 16'sd5},
      1, 5, DIR_HORIZ},
    '{'{KIND_BAD,     7'd0, 8'd0, 1'b1, 5'd3,  3'd0, 6'd8,  1'b1, 4'd1,  16'sd5},
      0, 0, DIR_NONE},
    '{'{KIND_PREDICT, 7'd0, 8'd0, 1'b0, 5'd3,  3'd6, 6'd8,  1'b1, 4'd1,  16'sd5},
      0, 0, DIR_NONE},
    '{'{KIND_ADD,     7'd0, 8'd0, 1'b0, 5'd3,  3'd0, 6'd8,  1'b1, 4'd15, 16'sd5},
      0, 0, DIR_NONE},
    '{'{KIND_HEADER,  7'd1, 8'd0, 1'b1, 5'd3,  3'd0, 6'd8,  1'b1, 4'd0,  16'sd5},
      0, 0, DIR_NONE},
    '{'{KIND_HEADER,  7'd0, 8'd1, 1'b0, 5'd31, 3'd0, 6'd8,  1'b1, 4'd0,  16'sd5},
      0, 0, DIR_NONE},
    '{'{KIND_PREDICT, 7'd0, 8'd2, 1'b0, 5'd31, 3'd5, 6'd63, 1'b0, 4'd0,  16'sd0},
      1, 16, DIR_HORIZ},
    '{'{KIND_ADD,     7'd0, 8'd2, 1'b0, 5'd31, 3'd5, 6'd63, 1'b0, 4'd0,  -16'sd1},
      1, 15, DIR_HORIZ}
  };

  initial begin
    for (int i = 0; i < 2 * COLS; i++) mb_info[i] = '0;
    for (int i = 0; i < 8; i++) pred_latch[i] = '0;
    dir_latch = DIR_NONE;
    scaler_latch = 1;
    width_reg = 1;
    repeat (5) @(posedge clk);
    rst <= 0;
    foreach (table_rows[i]) send(table_rows[i].rq, table_rows[i].chk, table_rows[i].ev,
                                 table_rows[i].ed);
    random_phase(3, 90);
    random_phase(1, 30);
    random_phase(128, 50);
    random_phase(2, 50);
    drain();
    $display("covered %0d requests and %0d results over widths 1, 2, 3 and 128",
             sent, received);
    if (errors == 0) begin
      $display("tb_mpeg4_acdc_intra_prediction_core: done, clean");
    end else begin
      $display("tb_mpeg4_acdc_intra_prediction_core: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", pending_coeffs.size());
    $display("tb_mpeg4_acdc_intra_prediction_core: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
